// File: hdl/lkf_pkg.sv
// Package for the linear Kalman filter core: sizes, codes, command and status
// structs, the controller state type and the Q16.16 rounding helpers.
// Depends on nothing; every other source file uses it.
`timescale 1ns / 1ps

package lkf_pkg;

    localparam int STATE_DIM = 4;
    localparam int MEAS_DIM  = 2;

    localparam int SW   = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
    localparam int MW   = (MEAS_DIM > 1) ? $clog2(MEAS_DIM) : 1;
    localparam int AW   = $clog2(2 * MEAS_DIM);
    localparam int MAXD = (STATE_DIM > 2 * MEAS_DIM) ? STATE_DIM : 2 * MEAS_DIM;
    localparam int CW   = $clog2(MAXD);
    localparam int ACCW = 34 + $clog2(STATE_DIM + 1);

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 32;

    typedef logic signed [31:0] t_q16;

    localparam t_q16 Q_ONE = 32'sh0001_0000;
    localparam t_q16 Q_MAX = 32'sh7FFF_FFFF;
    localparam t_q16 Q_MIN = 32'sh8000_0000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_MEAS = 1'b1;

    localparam logic [CFG_IW-1:0] CFG_STATE_DIM = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MEAS_DIM  = 2'd1;

    typedef enum logic [2:0] {
        TGT_A = 3'd0,
        TGT_Q = 3'd1,
        TGT_H = 3'd2,
        TGT_R = 3'd3,
        TGT_X = 3'd4,
        TGT_P = 3'd5
    } t_target;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_XA,
        ST_AP,
        ST_PA,
        ST_PHT,
        ST_S,
        ST_INIT,
        ST_PIV,
        ST_DIV,
        ST_DIVW,
        ST_ELIM,
        ST_K,
        ST_Y,
        ST_X,
        ST_HP,
        ST_P,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic          mac_valid;
        t_state        phase;
        logic [CW-1:0] i;
        logic [CW-1:0] j;
        logic [CW-1:0] k;
        logic [CW-1:0] c;
        logic [CW-1:0] ml;
        logic          first;
        logic          last;
        logic          in_accept;
        logic          sing_set;
        logic          sing_clr;
        logic          aug_init;
        logic          piv_do;
        logic          div_start;
        logic          div_wr;
        logic          out_load;
        logic          out_last;
    } t_cmd;

    typedef struct packed {
        logic zero_piv;
        logic div_done;
    } t_stat;

    // Round a full product to Q16.16 (add half, floor shift) and saturate.
    function automatic t_q16 sat_prod(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd32768) >>> 16;
        if ((&t[63:31]) || (~|t[63:31])) begin
            return t[31:0];
        end
        return t[63] ? Q_MIN : Q_MAX;
    endfunction

    function automatic t_q16 sat_acc(input logic signed [ACCW-1:0] v);
        if ((&v[ACCW-1:31]) || (~|v[ACCW-1:31])) begin
            return v[31:0];
        end
        return v[ACCW-1] ? Q_MIN : Q_MAX;
    endfunction

    function automatic logic signed [ACCW-1:0] sext(input t_q16 x);
        return {{(ACCW-32){x[31]}}, x};
    endfunction

endpackage

// File: hdl/lkf_if.sv
// Channel interfaces of the Kalman filter core: input words, result words and
// configuration writes. Depends on lkf_pkg for the configuration widths.
`timescale 1ns / 1ps

interface lkf_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [2:0]         target;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] value;
    logic               last_element;

    modport source (output valid, kind, target, row_index, col_index, value, last_element,
                    input ready);
    modport sink (input valid, kind, target, row_index, col_index, value, last_element,
                  output ready);
endinterface

interface lkf_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         element_index;
    logic signed [31:0] state_estimate;
    logic signed [31:0] error_variance;
    logic               singular;
    logic               last_result;

    modport source (output valid, element_index, state_estimate, error_variance, singular,
                    last_result, input ready);
    modport sink (input valid, element_index, state_estimate, error_variance, singular,
                  last_result, output ready);
endinterface

interface lkf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lkf_pkg::CFG_IW-1:0] index;
    logic [lkf_pkg::CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/lkf_div.sv
// Iterative signed Q16.16 divider, two quotient bits per cycle, truncating
// toward zero with saturation. Depends on lkf_pkg.
`timescale 1ns / 1ps

module lkf_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lkf_pkg::t_q16 i_num,
    input  lkf_pkg::t_q16 i_den,
    output logic          o_done,
    output lkf_pkg::t_q16 o_quot
);
    import lkf_pkg::*;

    localparam int NB    = 48;
    localparam int BPC   = 2;
    localparam int STEPS = NB / BPC;
    localparam int CNTW  = $clog2(STEPS);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [32:0]     r_rem;
    logic [NB-1:0]   r_num;
    logic [NB-1:0]   r_quo;
    logic [31:0]     r_den;
    logic            r_neg;
    t_q16            r_quot;

    logic [32:0]   n_rem;
    logic [NB-1:0] n_num;
    logic [NB-1:0] n_quo;
    t_q16          quot_sat;
    logic [31:0]   a_mag;
    logic [31:0]   b_mag;

    assign a_mag = i_num[31] ? (~i_num + 32'd1) : i_num;
    assign b_mag = i_den[31] ? (~i_den + 32'd1) : i_den;

    always_comb begin
        n_rem = r_rem;
        n_num = r_num;
        n_quo = r_quo;
        for (int b = 0; b < BPC; b++) begin
            n_rem = {n_rem[31:0], n_num[NB-1]};
            n_num = n_num << 1;
            if (n_rem >= {1'b0, r_den}) begin
                n_rem = n_rem - {1'b0, r_den};
                n_quo = {n_quo[NB-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[NB-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (!r_neg) begin
            quot_sat = (|n_quo[NB-1:31]) ? Q_MAX : n_quo[31:0];
        end else if ((|n_quo[NB-1:32]) || (n_quo[31] && (|n_quo[30:0]))) begin
            quot_sat = Q_MIN;
        end else begin
            quot_sat = ~n_quo[31:0] + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= {a_mag, 16'h0000};
            r_quo <= '0;
            r_den <= b_mag;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_quo <= n_quo;
            if (r_cnt == CNTW'(STEPS - 1)) begin
                r_quot <= quot_sat;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: hdl/lkf_dp.sv
// Datapath of the Kalman filter core: model and estimate stores, scratch
// matrices, the shared multiply-accumulate pipe, pivot search and divider.
// Depends on lkf_pkg and lkf_div.
`timescale 1ns / 1ps

module lkf_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lkf_pkg::t_cmd i_cmd,
    output lkf_pkg::t_stat o_stat,
    input  logic          i_kind,
    input  logic [2:0]    i_target,
    input  logic [1:0]    i_row,
    input  logic [1:0]    i_col,
    input  lkf_pkg::t_q16 i_value,
    output logic [1:0]    o_element_index,
    output lkf_pkg::t_q16 o_state_estimate,
    output lkf_pkg::t_q16 o_error_variance,
    output logic          o_singular,
    output logic          o_last_result
);
    import lkf_pkg::*;

    // Stored model and estimate.
    t_q16 r_a   [STATE_DIM][STATE_DIM];
    t_q16 r_q   [STATE_DIM][STATE_DIM];
    t_q16 r_h   [MEAS_DIM][STATE_DIM];
    t_q16 r_r   [MEAS_DIM][MEAS_DIM];
    t_q16 r_x   [STATE_DIM];
    t_q16 r_p   [STATE_DIM][STATE_DIM];
    t_q16 r_k   [STATE_DIM][MEAS_DIM];
    t_q16 r_z   [MEAS_DIM];
    logic r_sing;

    // Intermediate results of one step.
    t_q16 r_xa  [STATE_DIM];
    t_q16 r_ap  [STATE_DIM][STATE_DIM];
    t_q16 r_pa  [STATE_DIM][STATE_DIM];
    t_q16 r_pht [STATE_DIM][MEAS_DIM];
    t_q16 r_y   [MEAS_DIM];
    t_q16 r_hp  [MEAS_DIM][STATE_DIM];
    t_q16 r_aug [MEAS_DIM][2*MEAS_DIM];
    t_q16 r_piv;
    t_q16 r_f;

    // Multiply stage.
    logic                 r_s1_valid;
    logic signed [63:0]   r_prod;
    t_q16                 r_s1_init;
    logic                 r_s1_first;
    logic                 r_s1_last;
    logic                 r_s1_sub;
    t_state               r_s1_phase;
    logic [CW-1:0]        r_s1_i;
    logic [CW-1:0]        r_s1_j;
    logic signed [ACCW-1:0] r_acc;

    logic [1:0] r_o_idx;
    t_q16       r_o_x;
    t_q16       r_o_p;
    logic       r_o_sing;
    logic       r_o_last;

    logic [SW-1:0] si, sj, sk, ldr, ldc, wsi, wsj;
    logic [MW-1:0] mi, mj, mk, mc, wmi, wmj, best;
    logic [AW-1:0] aj, ajm, waj;
    t_q16 op_a, op_b, op_init;
    logic op_sub;
    logic signed [ACCW-1:0] base, prod_ext, n_acc;
    t_q16 acc_sat;
    logic [32:0] pv_mag [MEAS_DIM];
    logic [32:0] bmag;
    logic        found;
    logic        div_done;
    t_q16        div_q;

    assign si  = SW'(i_cmd.i);
    assign sj  = SW'(i_cmd.j);
    assign sk  = SW'(i_cmd.k);
    assign mi  = MW'(i_cmd.i);
    assign mj  = MW'(i_cmd.j);
    assign mk  = MW'(i_cmd.k);
    assign mc  = MW'(i_cmd.c);
    assign aj  = AW'(i_cmd.j);
    assign ajm = AW'(i_cmd.j) + AW'(i_cmd.ml) + AW'(1);
    assign ldr = SW'(i_row);
    assign ldc = SW'(i_col);
    assign wsi = SW'(r_s1_i);
    assign wsj = SW'(r_s1_j);
    assign wmi = MW'(r_s1_i);
    assign wmj = MW'(r_s1_j);
    assign waj = AW'(r_s1_j);

    // Operand selection for the shared multiply-accumulate.
    always_comb begin
        op_a    = '0;
        op_b    = '0;
        op_init = '0;
        op_sub  = 1'b0;
        unique case (i_cmd.phase)
            ST_XA: begin
                op_a = r_a[si][sk];
                op_b = r_x[sk];
            end
            ST_AP: begin
                op_a = r_a[si][sk];
                op_b = r_p[sk][sj];
            end
            ST_PA: begin
                op_a    = r_ap[si][sk];
                op_b    = r_a[sj][sk];
                op_init = r_q[si][sj];
            end
            ST_PHT: begin
                op_a = r_pa[si][sk];
                op_b = r_h[mj][sk];
            end
            ST_S: begin
                op_a    = r_h[mi][sk];
                op_b    = r_pht[sk][mj];
                op_init = r_r[mi][mj];
            end
            ST_ELIM: begin
                // The row factor is taken before the row itself changes.
                op_a    = (i_cmd.j == '0) ? r_aug[mi][mc] : r_f;
                op_b    = r_aug[mc][aj];
                op_init = r_aug[mi][aj];
                op_sub  = 1'b1;
            end
            ST_K: begin
                op_a = r_pht[si][mk];
                op_b = r_aug[mk][ajm];
            end
            ST_Y: begin
                op_a    = r_h[mi][sk];
                op_b    = r_xa[sk];
                op_init = r_z[mi];
                op_sub  = 1'b1;
            end
            ST_X: begin
                op_a    = r_k[si][mk];
                op_b    = r_y[mk];
                op_init = r_xa[si];
            end
            ST_HP: begin
                op_a = r_h[mi][sk];
                op_b = r_pa[sk][sj];
            end
            ST_P: begin
                op_a    = r_k[si][mk];
                op_b    = r_hp[mk][sj];
                op_init = r_pa[si][sj];
                op_sub  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign prod_ext = sext(sat_prod(r_prod));
    assign base     = r_s1_first ? sext(r_s1_init) : r_acc;
    assign n_acc    = r_s1_sub ? (base - prod_ext) : (base + prod_ext);
    assign acc_sat  = sat_acc(n_acc);

    // Pivot search over the rows at and below the current column.
    always_comb begin
        logic signed [32:0] xs;
        bmag  = '0;
        best  = mc;
        found = 1'b0;
        for (int r = 0; r < MEAS_DIM; r++) begin
            xs        = {r_aug[r][mc][31], r_aug[r][mc]};
            pv_mag[r] = xs[32] ? 33'(-xs) : 33'(xs);
        end
        for (int r = 0; r < MEAS_DIM; r++) begin
            if ((r >= int'(i_cmd.c)) && (r <= int'(i_cmd.ml))) begin
                if (!found || (pv_mag[r] > bmag)) begin
                    found = 1'b1;
                    bmag  = pv_mag[r];
                    best  = MW'(r);
                end
            end
        end
    end

    lkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_aug[mc][aj]),
        .i_den   (r_piv),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_stat.zero_piv = (bmag == '0);
    assign o_stat.div_done = div_done;

    // Multiply stage and accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.mac_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_valid) begin
            r_prod     <= op_a * op_b;
            r_s1_init  <= op_init;
            r_s1_first <= i_cmd.first;
            r_s1_last  <= i_cmd.last;
            r_s1_sub   <= op_sub;
            r_s1_phase <= i_cmd.phase;
            r_s1_i     <= i_cmd.i;
            r_s1_j     <= i_cmd.j;
        end
        if (r_s1_valid) begin
            r_acc <= n_acc;
        end
    end

    // Stored state: loads from the input channel and final step results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < STATE_DIM; r++) begin
                r_x[r] <= '0;
                for (int c = 0; c < STATE_DIM; c++) begin
                    r_a[r][c] <= '0;
                    r_q[r][c] <= '0;
                    r_p[r][c] <= '0;
                end
                for (int c = 0; c < MEAS_DIM; c++) begin
                    r_k[r][c] <= '0;
                end
            end
            for (int r = 0; r < MEAS_DIM; r++) begin
                for (int c = 0; c < STATE_DIM; c++) begin
                    r_h[r][c] <= '0;
                end
                for (int c = 0; c < MEAS_DIM; c++) begin
                    r_r[r][c] <= '0;
                end
            end
            r_sing <= 1'b0;
        end else begin
            if (i_cmd.in_accept && (i_kind == KIND_LOAD)) begin
                case (i_target)
                    TGT_A: if ((int'(i_row) < STATE_DIM) && (int'(i_col) < STATE_DIM))
                        r_a[ldr][ldc] <= i_value;
                    TGT_Q: if ((int'(i_row) < STATE_DIM) && (int'(i_col) < STATE_DIM))
                        r_q[ldr][ldc] <= i_value;
                    TGT_H: if ((int'(i_row) < MEAS_DIM) && (int'(i_col) < STATE_DIM))
                        r_h[MW'(i_row)][ldc] <= i_value;
                    TGT_R: if ((int'(i_row) < MEAS_DIM) && (int'(i_col) < MEAS_DIM))
                        r_r[MW'(i_row)][MW'(i_col)] <= i_value;
                    TGT_X: if (int'(i_row) < STATE_DIM)
                        r_x[ldr] <= i_value;
                    TGT_P: if ((int'(i_row) < STATE_DIM) && (int'(i_col) < STATE_DIM))
                        r_p[ldr][ldc] <= i_value;
                    default: begin
                    end
                endcase
            end
            if (r_s1_valid && r_s1_last) begin
                case (r_s1_phase)
                    ST_K: r_k[wsi][wmj] <= acc_sat;
                    ST_X: r_x[wsi] <= acc_sat;
                    ST_P: r_p[wsi][wsj] <= acc_sat;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.sing_clr) begin
                r_sing <= 1'b0;
            end else if (i_cmd.sing_set) begin
                r_sing <= 1'b1;
            end
        end
    end

    // Scratch matrices, the Gauss-Jordan array and the result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_accept && (i_kind == KIND_MEAS) && (int'(i_row) < MEAS_DIM)) begin
            r_z[MW'(i_row)] <= i_value;
        end
        if (i_cmd.mac_valid && (i_cmd.phase == ST_ELIM) && (i_cmd.j == '0)) begin
            r_f <= r_aug[mi][mc];
        end
        if (r_s1_valid && r_s1_last) begin
            case (r_s1_phase)
                ST_XA:   r_xa[wsi] <= acc_sat;
                ST_AP:   r_ap[wsi][wsj] <= acc_sat;
                ST_PA:   r_pa[wsi][wsj] <= acc_sat;
                ST_PHT:  r_pht[wsi][wmj] <= acc_sat;
                ST_S:    r_aug[wmi][waj] <= acc_sat;
                ST_ELIM: r_aug[wmi][waj] <= acc_sat;
                ST_Y:    r_y[wmi] <= acc_sat;
                ST_HP:   r_hp[wmi][wsj] <= acc_sat;
                default: begin
                end
            endcase
        end
        if (i_cmd.aug_init) begin
            // Identity block to the right of the innovation covariance.
            for (int r = 0; r < MEAS_DIM; r++) begin
                for (int c = 0; c < 2 * MEAS_DIM; c++) begin
                    if (c > int'(i_cmd.ml)) begin
                        r_aug[r][c] <= (c - int'(i_cmd.ml) - 1 == r) ? Q_ONE : '0;
                    end
                end
            end
        end
        if (i_cmd.piv_do) begin
            r_piv <= r_aug[best][mc];
            if (best != mc) begin
                for (int c = 0; c < 2 * MEAS_DIM; c++) begin
                    r_aug[mc][c]   <= r_aug[best][c];
                    r_aug[best][c] <= r_aug[mc][c];
                end
            end
        end
        if (i_cmd.div_wr) begin
            r_aug[mc][aj] <= div_q;
        end
        if (i_cmd.out_load) begin
            r_o_idx  <= 2'(i_cmd.i);
            r_o_x    <= r_x[si];
            r_o_p    <= r_p[si][si];
            r_o_sing <= r_sing;
            r_o_last <= i_cmd.out_last;
        end
    end

    assign o_element_index  = r_o_idx;
    assign o_state_estimate = r_o_x;
    assign o_error_variance = r_o_p;
    assign o_singular       = r_o_sing;
    assign o_last_result    = r_o_last;

endmodule

// File: hdl/lkf_ctrl.sv
// Controller of the Kalman filter core: dimension registers, the phase state
// machine with its loop counters, and the handshakes. Depends on lkf_pkg.
`timescale 1ns / 1ps

module lkf_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_kind,
    input  logic                       i_in_last,
    output logic                       o_in_ready,
    input  logic                       i_cfg_valid,
    input  logic [lkf_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [lkf_pkg::CFG_DW-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    input  lkf_pkg::t_stat             i_stat,
    output lkf_pkg::t_cmd              o_cmd
);
    import lkf_pkg::*;

    t_state        r_state, n_state;
    logic [CW-1:0] r_i, r_j, r_k, r_c;
    logic [CW-1:0] n_i, n_j, n_k, n_c;
    logic          r_tail, n_tail;
    logic          r_ovalid, n_ovalid;
    logic [2:0]    r_sdim;
    logic [1:0]    r_mdim;

    logic [CW-1:0] nl, ml, m2l;
    logic [CW-1:0] ilast, jlast, klast;
    logic [CW-1:0] inext;
    logic          is_mac;
    logic          start;
    logic          out_free;
    t_state        after;

    always_comb begin
        if (r_sdim == '0) begin
            nl = '0;
        end else if (int'(r_sdim) > STATE_DIM) begin
            nl = CW'(STATE_DIM - 1);
        end else begin
            nl = CW'(r_sdim - 3'd1);
        end
        if (r_mdim == '0) begin
            ml = '0;
        end else if (int'(r_mdim) > MEAS_DIM) begin
            ml = CW'(MEAS_DIM - 1);
        end else begin
            ml = CW'(r_mdim - 2'd1);
        end
    end

    assign m2l      = CW'((int'(ml) << 1) + 1);
    assign start    = i_in_valid && (i_in_kind == KIND_MEAS) && i_in_last;
    assign out_free = !r_ovalid || i_out_ready;

    // Loop bounds of each accumulate phase and the phase that follows it.
    always_comb begin
        ilast  = '0;
        jlast  = '0;
        klast  = '0;
        is_mac = 1'b1;
        after  = ST_IDLE;
        unique case (r_state)
            ST_XA:   begin ilast = nl; klast = nl; after = ST_AP; end
            ST_AP:   begin ilast = nl; jlast = nl; klast = nl; after = ST_PA; end
            ST_PA:   begin ilast = nl; jlast = nl; klast = nl; after = ST_PHT; end
            ST_PHT:  begin ilast = nl; jlast = ml; klast = nl; after = ST_S; end
            ST_S:    begin ilast = ml; jlast = ml; klast = nl; after = ST_INIT; end
            ST_ELIM: begin
                ilast = (r_c == ml) ? (ml - 1'b1) : ml;
                jlast = m2l;
                after = (r_c == ml) ? ST_K : ST_PIV;
            end
            ST_K:    begin ilast = nl; jlast = ml; klast = ml; after = ST_Y; end
            ST_Y:    begin ilast = ml; klast = nl; after = ST_X; end
            ST_X:    begin ilast = nl; klast = ml; after = ST_HP; end
            ST_HP:   begin ilast = ml; jlast = nl; klast = nl; after = ST_P; end
            ST_P:    begin ilast = nl; jlast = nl; klast = ml; after = ST_OUT; end
            default: is_mac = 1'b0;
        endcase
    end

    // The elimination pass skips the pivot row.
    assign inext = ((r_state == ST_ELIM) && (r_i + 1'b1 == r_c)) ? (r_i + 2'd2) : (r_i + 1'b1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_XA;
            ST_INIT: n_state = ST_PIV;
            ST_PIV:  n_state = i_stat.zero_piv ? ST_OUT : ST_DIV;
            ST_DIV:  n_state = ST_DIVW;
            ST_DIVW: begin
                if (i_stat.div_done) begin
                    if (r_j != m2l) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = (ml == '0) ? ST_K : ST_ELIM;
                    end
                end
            end
            ST_OUT:  if (out_free && (r_i == nl)) n_state = ST_IDLE;
            default: if (is_mac && r_tail) n_state = after;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.phase = r_state;
        o_cmd.i     = r_i;
        o_cmd.j     = r_j;
        o_cmd.k     = r_k;
        o_cmd.c     = r_c;
        o_cmd.ml    = ml;
        o_cmd.first = (r_k == '0);
        o_cmd.last  = (r_k == klast);
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_c         = r_c;
        n_tail      = r_tail;
        n_ovalid    = r_ovalid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_accept = i_in_valid;
                if (start) begin
                    o_cmd.sing_clr = 1'b1;
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                    n_c = '0;
                end
            end
            ST_INIT: o_cmd.aug_init = 1'b1;
            ST_PIV: begin
                o_cmd.sing_set = i_stat.zero_piv;
                o_cmd.piv_do   = !i_stat.zero_piv;
                n_i = '0;
                n_j = '0;
            end
            ST_DIV: o_cmd.div_start = 1'b1;
            ST_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    if (r_j == m2l) begin
                        n_j = '0;
                        n_k = '0;
                        n_i = ((ml != '0) && (r_c == '0)) ? CW'(1) : '0;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_i == nl);
                    n_ovalid = 1'b1;
                    n_i = r_i + 1'b1;
                end
            end
            default: begin
                if (is_mac && !r_tail) begin
                    o_cmd.mac_valid = 1'b1;
                    if (r_k != klast) begin
                        n_k = r_k + 1'b1;
                    end else begin
                        n_k = '0;
                        if (r_j != jlast) begin
                            n_j = r_j + 1'b1;
                        end else begin
                            n_j = '0;
                            if (r_i != ilast) begin
                                n_i = inext;
                            end else begin
                                n_tail = 1'b1;
                            end
                        end
                    end
                end else if (is_mac) begin
                    // An idle tail step lets the last sum land before the next phase reads it.
                    n_tail = 1'b0;
                    n_i    = '0;
                    n_j    = '0;
                    n_k    = '0;
                    if (r_state == ST_ELIM) begin
                        n_c = r_c + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_c      <= '0;
            r_tail   <= 1'b0;
            r_ovalid <= 1'b0;
            r_sdim   <= 3'd4;
            r_mdim   <= 2'd2;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_c      <= n_c;
            r_tail   <= n_tail;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_STATE_DIM) begin
                    r_sdim <= i_cfg_data[2:0];
                end else if (i_cfg_index == CFG_MEAS_DIM) begin
                    r_mdim <= i_cfg_data[1:0];
                end
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;

endmodule

// File: hdl/linear_kalman_filter_core.sv
// Linear Kalman filter core, signed Q16.16 with saturation; one step at a time.
// Loads and plain measurement words are stored as they are taken. A measurement word marked
// last runs a step: one issue per cycle on the shared multiplier, a drain step after each
// phase, and a divide for each entry of the pivot row. The results then follow one per cycle
// while the receiver is ready, and the next word is taken after the last has been loaded.
// Reset is synchronous and active low; it zeroes every stored matrix, the state and the gain.
`timescale 1ns / 1ps

module linear_kalman_filter_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lkf_in_if.sink    i_in,
    lkf_out_if.source o_out,
    lkf_cfg_if.sink   i_cfg
);
    import lkf_pkg::*;

    // The controller owns the handshakes and loop counters; the datapath owns every
    // stored word and the arithmetic. They talk only through the command and status
    // structs below.
    t_cmd  cmd;
    t_stat stat;

    lkf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .i_in_last   (i_in.last_element),
        .o_in_ready  (i_in.ready),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_cfg_ready (i_cfg.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Results leave through a registered word, so a new step can load while the
    // last result of the previous one still waits to be taken.
    lkf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_kind           (i_in.kind),
        .i_target         (i_in.target),
        .i_row            (i_in.row_index),
        .i_col            (i_in.col_index),
        .i_value          (i_in.value),
        .o_element_index  (o_out.element_index),
        .o_state_estimate (o_out.state_estimate),
        .o_error_variance (o_out.error_variance),
        .o_singular       (o_out.singular),
        .o_last_result    (o_out.last_result)
    );

endmodule

// File: sim/linear_kalman_filter_core_tb.sv
// Self-checking testbench of the linear Kalman filter core: directed and random words,
// bit-exact Q16.16 prediction of every estimate word, back-pressure and a watchdog.
// Depends on lkf_pkg, the channel interfaces in lkf_if and the core itself.
`timescale 1ns / 1ps

module linear_kalman_filter_core_tb;
    import lkf_pkg::*;

    // Targets that the core has no store for; loads to them are dropped.
    localparam logic [2:0] TGT_NONE_6 = 3'd6;
    localparam logic [2:0] TGT_NONE_7 = 3'd7;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES = 600;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [1:0]         element_index;
        logic signed [31:0] state_estimate;
        logic signed [31:0] error_variance;
        logic               singular;
        logic               last_result;
    } t_estimate;

    logic i_clk;
    logic i_rst_n;

    lkf_in_if  in_ch();
    lkf_out_if out_ch();
    lkf_cfg_if cfg_ch();

    linear_kalman_filter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow copy of everything the core stores, indexed as the core lays it out.
    t_q16 kf_a [STATE_DIM*STATE_DIM];
    t_q16 kf_q [STATE_DIM*STATE_DIM];
    t_q16 kf_h [MEAS_DIM*STATE_DIM];
    t_q16 kf_r [MEAS_DIM*MEAS_DIM];
    t_q16 kf_x [STATE_DIM];
    t_q16 kf_p [STATE_DIM*STATE_DIM];
    t_q16 kf_k [STATE_DIM*MEAS_DIM];
    t_q16 kf_z [MEAS_DIM];
    int unsigned state_dim_reg;
    int unsigned meas_dim_reg;

    t_estimate pending_estimates[$];
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_left;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------
    // Fixed-point helpers of the shadow model.
    // ---------------------------------------------------------------------------
    function automatic t_q16 q_sat(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return Q_MAX;
        if (v < -longint'(32'sh7FFF_FFFF) - 1) return Q_MIN;
        return t_q16'(v);
    endfunction

    // Exact product plus one half, floor shift by 16, then saturation.
    function automatic t_q16 q_mul(input t_q16 a, input t_q16 b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return q_sat(p >>> 16);
    endfunction

    // SystemVerilog signed division truncates toward zero, as the core does.
    function automatic t_q16 q_div(input t_q16 a, input t_q16 b);
        longint num;
        num = longint'(a) * 64'sd65536;
        return q_sat(num / longint'(b));
    endfunction

    function automatic t_q16 q_sub(input t_q16 a, input t_q16 b);
        return q_sat(longint'(a) - longint'(b));
    endfunction

    // ---------------------------------------------------------------------------
    // One full predict and update step on the shadow state. Returns 1 when the
    // innovation covariance has no usable pivot, in which case nothing changes.
    // ---------------------------------------------------------------------------
    function automatic logic kalman_step(input int n, input int m);
        t_q16 xa [STATE_DIM];
        t_q16 ap [STATE_DIM][STATE_DIM];
        t_q16 pa [STATE_DIM][STATE_DIM];
        t_q16 pht [STATE_DIM][MEAS_DIM];
        t_q16 s [MEAS_DIM][MEAS_DIM];
        t_q16 aug [MEAS_DIM][2*MEAS_DIM];
        t_q16 kk [STATE_DIM][MEAS_DIM];
        t_q16 y [MEAS_DIM];
        t_q16 hp [MEAS_DIM][STATE_DIM];
        t_q16 piv, f, t;
        longint acc, mag, best_mag;
        int best;
        for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int k = 0; k < n; k++) acc += q_mul(kf_a[i*STATE_DIM+k], kf_x[k]);
            xa[i] = q_sat(acc);
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc += q_mul(kf_a[i*STATE_DIM+k], kf_p[k*STATE_DIM+j]);
                ap[i][j] = q_sat(acc);
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = kf_q[i*STATE_DIM+j];
                for (int k = 0; k < n; k++) acc += q_mul(ap[i][k], kf_a[j*STATE_DIM+k]);
                pa[i][j] = q_sat(acc);
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < m; j++) begin
                acc = 0;
                for (int k = 0; k < n; k++) acc += q_mul(pa[i][k], kf_h[j*STATE_DIM+k]);
                pht[i][j] = q_sat(acc);
            end
        end
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < m; j++) begin
                acc = kf_r[i*MEAS_DIM+j];
                for (int k = 0; k < n; k++) acc += q_mul(kf_h[i*STATE_DIM+k], pht[k][j]);
                s[i][j] = q_sat(acc);
            end
        end
        // Gauss-Jordan on [S | I] with partial pivoting.
        for (int r = 0; r < m; r++) begin
            for (int j = 0; j < 2*m; j++) begin
                aug[r][j] = (j < m) ? s[r][j] : ((j - m == r) ? Q_ONE : 32'sd0);
            end
        end
        for (int c = 0; c < m; c++) begin
            best = c;
            best_mag = -1;
            for (int r = c; r < m; r++) begin
                mag = longint'(aug[r][c]);
                if (mag < 0) mag = -mag;
                if (mag > best_mag) begin
                    best_mag = mag;
                    best = r;
                end
            end
            if (best_mag == 0) return 1'b1;
            if (best != c) begin
                for (int j = 0; j < 2*m; j++) begin
                    t = aug[c][j];
                    aug[c][j] = aug[best][j];
                    aug[best][j] = t;
                end
            end
            piv = aug[c][c];
            for (int j = 0; j < 2*m; j++) aug[c][j] = q_div(aug[c][j], piv);
            for (int i = 0; i < m; i++) begin
                if (i != c) begin
                    f = aug[i][c];
                    for (int j = 0; j < 2*m; j++) aug[i][j] = q_sub(aug[i][j], q_mul(f, aug[c][j]));
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < m; j++) begin
                acc = 0;
                for (int k = 0; k < m; k++) acc += q_mul(pht[i][k], aug[k][m+j]);
                kk[i][j] = q_sat(acc);
                kf_k[i*MEAS_DIM+j] = kk[i][j];
            end
        end
        for (int i = 0; i < m; i++) begin
            acc = kf_z[i];
            for (int k = 0; k < n; k++) acc -= q_mul(kf_h[i*STATE_DIM+k], xa[k]);
            y[i] = q_sat(acc);
        end
        for (int i = 0; i < n; i++) begin
            acc = xa[i];
            for (int k = 0; k < m; k++) acc += q_mul(kk[i][k], y[k]);
            kf_x[i] = q_sat(acc);
        end
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = 0;
                for (int k = 0; k < n; k++) acc += q_mul(kf_h[i*STATE_DIM+k], pa[k][j]);
                hp[i][j] = q_sat(acc);
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = pa[i][j];
                for (int k = 0; k < m; k++) acc -= q_mul(kk[i][k], hp[k][j]);
                kf_p[i*STATE_DIM+j] = q_sat(acc);
            end
        end
        return 1'b0;
    endfunction

    // Applies one accepted input word to the shadow state and queues the
    // estimate words that it causes.
    task automatic predict_word(input logic kind, input logic [2:0] target,
                                input logic [1:0] row, input logic [1:0] col,
                                input t_q16 value, input logic last);
        int n, m;
        logic sing;
        t_estimate e;
        if (kind == KIND_LOAD) begin
            case (target)
                TGT_A: kf_a[row*STATE_DIM+col] = value;
                TGT_Q: kf_q[row*STATE_DIM+col] = value;
                TGT_H: if (row < MEAS_DIM) kf_h[row*STATE_DIM+col] = value;
                TGT_R: if (row < MEAS_DIM && col < MEAS_DIM) kf_r[row*MEAS_DIM+col] = value;
                TGT_X: kf_x[row] = value;
                TGT_P: kf_p[row*STATE_DIM+col] = value;
                default: ;
            endcase
            return;
        end
        if (row < MEAS_DIM) kf_z[row] = value;
        if (!last) return;
        n = (state_dim_reg < 1) ? 1 : ((state_dim_reg > STATE_DIM) ? STATE_DIM : state_dim_reg);
        m = (meas_dim_reg < 1) ? 1 : ((meas_dim_reg > MEAS_DIM) ? MEAS_DIM : meas_dim_reg);
        sing = kalman_step(n, m);
        for (int i = 0; i < n; i++) begin
            e.element_index  = i[1:0];
            e.state_estimate = kf_x[i];
            e.error_variance = kf_p[i*STATE_DIM+i];
            e.singular       = sing;
            e.last_result    = (i == n - 1);
            pending_estimates.push_back(e);
        end
    endtask

    // ---------------------------------------------------------------------------
    // Input channel: drive at the falling edge, take the handshake at the rising
    // edge. Valid stays high across back-to-back words unless a gap is drawn.
    // ---------------------------------------------------------------------------
    task automatic send_word(input logic kind, input logic [2:0] target,
                             input logic [1:0] row, input logic [1:0] col,
                             input t_q16 value, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.kind         = kind;
        in_ch.target       = target;
        in_ch.row_index    = row;
        in_ch.col_index    = col;
        in_ch.value        = value;
        in_ch.last_element = last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_word(kind, target, row, col, value, last);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IW-1:0] index, input int unsigned data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (index == CFG_STATE_DIM) state_dim_reg = data & 7;
        else if (index == CFG_MEAS_DIM) meas_dim_reg = data & 3;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Waits until every queued estimate word has arrived, then lets a load or
    // a plain measurement word still in flight settle.
    task automatic wait_drained();
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly small values keep the filter out of saturation; the rest spans all bits.
    function automatic t_q16 random_value();
        if ($urandom_range(99) < 80) return t_q16'(int'($urandom_range(262143)) - 131072);
        return t_q16'($urandom);
    endfunction

    // One random word: mostly in-range loads and measurement runs, some noise.
    task automatic send_random_word();
        int pick;
        logic [1:0] row;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_word(KIND_LOAD, 3'($urandom_range(TGT_P)), 2'($urandom), 2'($urandom),
                      random_value(), 1'($urandom));
        end else if (pick < 65) begin
            send_word(1'($urandom), 3'($urandom), 2'($urandom), 2'($urandom),
                      t_q16'($urandom), 1'($urandom));
        end else begin
            row = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(MEAS_DIM - 1));
            send_word(KIND_MEAS, 3'($urandom), row, 2'($urandom), random_value(),
                      $urandom_range(99) < 40);
        end
    endtask

    // ---------------------------------------------------------------------------
    // Named tests.
    // ---------------------------------------------------------------------------
    task automatic test_directed();
        // Fill the measurement buffer first so that no step reads an unwritten entry.
        send_word(KIND_MEAS, 3'd0, 2'd0, 2'd0, Q_ONE, 1'b0);
        send_word(KIND_MEAS, 3'd0, 2'd1, 2'd3, -Q_ONE, 1'b0);
        for (int i = 0; i < STATE_DIM; i++)
            send_word(KIND_LOAD, TGT_A, 2'(i), 2'(i), Q_ONE, 1'b0);
        // Extreme state values; the column is ignored for the vector.
        send_word(KIND_LOAD, TGT_X, 2'd0, 2'd3, Q_MAX, 1'b0);
        send_word(KIND_LOAD, TGT_X, 2'd1, 2'd2, Q_MIN, 1'b0);
        send_word(KIND_LOAD, TGT_P, 2'd0, 2'd0, Q_ONE, 1'b0);
        // With H and R still zero the innovation covariance is singular.
        send_word(KIND_MEAS, 3'd0, 2'd0, 2'd0, 32'sd0, 1'b1);
        send_word(KIND_LOAD, TGT_H, 2'd0, 2'd0, Q_ONE, 1'b0);
        send_word(KIND_LOAD, TGT_H, 2'd1, 2'd1, Q_ONE, 1'b0);
        send_word(KIND_LOAD, TGT_R, 2'd0, 2'd0, Q_ONE, 1'b0);
        send_word(KIND_LOAD, TGT_R, 2'd1, 2'd1, Q_ONE, 1'b0);
        send_word(KIND_LOAD, TGT_Q, 2'd3, 2'd3, Q_ONE, 1'b0);
        send_word(KIND_MEAS, 3'd7, 2'd1, 2'd0, 32'sh0002_0000, 1'b1);
        // Out-of-range rows and columns and unknown targets must change nothing.
        send_word(KIND_LOAD, TGT_H, 2'd3, 2'd0, Q_MAX, 1'b1);
        send_word(KIND_LOAD, TGT_R, 2'd0, 2'd3, Q_MIN, 1'b0);
        send_word(KIND_LOAD, TGT_NONE_6, 2'd0, 2'd0, Q_MAX, 1'b0);
        send_word(KIND_LOAD, TGT_NONE_7, 2'd1, 2'd1, Q_MIN, 1'b0);
        // A measurement index beyond the buffer is dropped but still runs the step.
        send_word(KIND_MEAS, 3'd0, 2'd3, 2'd0, Q_MAX, 1'b1);
        end_burst();
        wait_drained();
    endtask

    task automatic test_dimensions();
        int unsigned n_set [6] = '{0, 1, 4, 7, 2, 3};
        int unsigned m_set [6] = '{0, 1, 2, 3, 1, 2};
        for (int s = 0; s < 6; s++) begin
            write_register(CFG_STATE_DIM, n_set[s]);
            write_register(CFG_MEAS_DIM, m_set[s]);
            for (int w = 0; w < 12; w++) send_random_word();
            send_word(KIND_MEAS, 3'd0, 2'd0, 2'd0, random_value(), 1'b1);
            end_burst();
            wait_drained();
        end
        write_register(CFG_STATE_DIM, STATE_DIM);
        write_register(CFG_MEAS_DIM, MEAS_DIM);
    endtask

    task automatic test_random(input int snd_pct, input int rcv_pct, input int count);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int w = 0; w < count; w++) send_random_word();
        end_burst();
        wait_drained();
    endtask

    // The receiver stops for a long stretch while steps keep coming, so the core
    // fills up and must stall its input; then the sender waits for a full drain.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_left = HOLD_OFF_CYCLES;
        for (int w = 0; w < 6; w++)
            send_word(KIND_MEAS, 3'd0, 2'(w % MEAS_DIM), 2'd0, random_value(), 1'b1);
        end_burst();
        wait_drained();
    endtask

    // ---------------------------------------------------------------------------
    // Receiver side: ready changes at the falling edge, either held off for a
    // counted stretch or drawn at random.
    // ---------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted estimate word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_estimate e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_estimates.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: estimate word with nothing expected: idx %0d x %0d p %0d",
                             $realtime, out_ch.element_index, out_ch.state_estimate,
                             out_ch.error_variance);
            end else begin
                e = pending_estimates.pop_front();
                if (out_ch.element_index !== e.element_index
                    || out_ch.state_estimate !== e.state_estimate
                    || out_ch.error_variance !== e.error_variance
                    || out_ch.singular !== e.singular
                    || out_ch.last_result !== e.last_result) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: expected idx %0d x %0d p %0d sing %0b last %0b,",
                                 $realtime, e.element_index, e.state_estimate,
                                 e.error_variance, e.singular, e.last_result);
                        $display("    got idx %0d x %0d p %0d sing %0b last %0b",
                                 out_ch.element_index, out_ch.state_estimate,
                                 out_ch.error_variance, out_ch.singular,
                                 out_ch.last_result);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which no channel moves a word.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_LOAD;
        in_ch.target = TGT_A;
        in_ch.row_index = 2'd0;
        in_ch.col_index = 2'd0;
        in_ch.value = 32'sd0;
        in_ch.last_element = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_STATE_DIM;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        hold_off_left = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        state_dim_reg = STATE_DIM;
        meas_dim_reg = MEAS_DIM;
        foreach (kf_a[i]) kf_a[i] = '0;
        foreach (kf_q[i]) kf_q[i] = '0;
        foreach (kf_h[i]) kf_h[i] = '0;
        foreach (kf_r[i]) kf_r[i] = '0;
        foreach (kf_x[i]) kf_x[i] = '0;
        foreach (kf_p[i]) kf_p[i] = '0;
        foreach (kf_k[i]) kf_k[i] = '0;
        foreach (kf_z[i]) kf_z[i] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_dimensions();
        test_random(22, 46, 70);
        test_random(46, 22, 70);
        test_random(0, 0, 70);
        test_backpressure();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_estimates.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/lkf_pkg.sv
hdl/lkf_if.sv
hdl/lkf_div.sv
hdl/lkf_dp.sv
hdl/lkf_ctrl.sv
hdl/linear_kalman_filter_core.sv
sim/linear_kalman_filter_core_tb.sv
